/* hdl/hfu_pkg.sv */
// ----------------------------------------------------------------------------
// hfu_pkg
// shared types, register indexes and protocol constants of the rtp fu-a
// packetizer
// ----------------------------------------------------------------------------
package hfu_pkg;

    // nal unit length field
    localparam int UNIT_LENGTH_BITS = 24;
    // width used when comparing lengths against the chunk size
    localparam int CMP_BITS = (UNIT_LENGTH_BITS > 16) ? UNIT_LENGTH_BITS : 16;

    // command queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAD_WORD   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_ID   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_SIZE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TS_STEP     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEQ_START   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TS_START    = 3'd6;

    // register reset values
    localparam logic [15:0] RST_LEAD_WORD  = 16'h8060;
    localparam logic [31:0] RST_SOURCE_ID  = 32'd0;
    localparam logic [7:0]  RST_CHANNEL    = 8'd0;
    localparam logic [15:0] RST_CHUNK_SIZE = 16'd1400;
    localparam logic [31:0] RST_TS_STEP    = 32'd3000;
    localparam logic [15:0] RST_SEQ_START  = 16'd0;
    localparam logic [31:0] RST_TS_START   = 32'd0;

    // framing constants
    localparam logic [15:0] MAX_CHUNK       = 16'd65521;
    localparam logic [7:0]  INTERLEAVE_MARK = 8'h24;
    localparam logic [7:0]  NRI_MASK        = 8'h60;
    localparam logic [7:0]  TYPE_MASK       = 8'h1F;
    localparam logic [7:0]  FU_A_TYPE       = 8'd28;
    localparam logic [7:0]  FU_START_BIT    = 8'h80;
    localparam logic [7:0]  FU_END_BIT      = 8'h40;
    localparam logic [4:0]  NAL_SPS         = 5'd7;
    localparam logic [4:0]  NAL_PPS         = 5'd8;
    localparam logic [15:0] RTP_HDR_BYTES   = 16'd12;
    localparam logic [15:0] FU_HDR_BYTES    = 16'd2;

    // byte positions within one command, header slots then the data byte
    localparam int POS_BITS = 5;
    localparam logic [POS_BITS-1:0] POS_MARK      = 5'd0;
    localparam logic [POS_BITS-1:0] POS_CHANNEL   = 5'd1;
    localparam logic [POS_BITS-1:0] POS_PLEN_HI   = 5'd2;
    localparam logic [POS_BITS-1:0] POS_PLEN_LO   = 5'd3;
    localparam logic [POS_BITS-1:0] POS_LEAD_HI   = 5'd4;
    localparam logic [POS_BITS-1:0] POS_LEAD_LO   = 5'd5;
    localparam logic [POS_BITS-1:0] POS_SEQ_HI    = 5'd6;
    localparam logic [POS_BITS-1:0] POS_SEQ_LO    = 5'd7;
    localparam logic [POS_BITS-1:0] POS_TS_3      = 5'd8;
    localparam logic [POS_BITS-1:0] POS_TS_2      = 5'd9;
    localparam logic [POS_BITS-1:0] POS_TS_1      = 5'd10;
    localparam logic [POS_BITS-1:0] POS_TS_0      = 5'd11;
    localparam logic [POS_BITS-1:0] POS_SSRC_3    = 5'd12;
    localparam logic [POS_BITS-1:0] POS_SSRC_2    = 5'd13;
    localparam logic [POS_BITS-1:0] POS_SSRC_1    = 5'd14;
    localparam logic [POS_BITS-1:0] POS_SSRC_0    = 5'd15;
    localparam logic [POS_BITS-1:0] POS_FU_IND    = 5'd16;
    localparam logic [POS_BITS-1:0] POS_FU_HDR    = 5'd17;
    localparam logic [POS_BITS-1:0] POS_DATA      = 5'd18;

    typedef struct packed {
        logic [7:0]                  data_byte;
        logic                        unit_start;
        logic [UNIT_LENGTH_BITS-1:0] unit_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [15:0] lead_word;
        logic [31:0] source_id;
        logic [7:0]  channel;
        logic [15:0] chunk_size;
        logic [31:0] ts_step;
    } t_cfg;

    // state loads caused by configuration writes
    typedef struct packed {
        logic        seq_load;
        logic [15:0] seq_value;
        logic        ts_load;
        logic [31:0] ts_value;
    } t_load;

    // one queued command: optional packet header, then one data byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_end;
        logic        has_hdr;
        logic        has_fu;
        logic [15:0] plen;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
    } t_cmd;

endpackage

/* hdl/hfu_front.sv */
// ----------------------------------------------------------------------------
// hfu_front
// accepts nal bytes, tracks unit and packet state, queues byte commands
// ----------------------------------------------------------------------------
module hfu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hfu_pkg::t_in  i_in_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hfu_pkg::t_cfg i_cfg,
    input  hfu_pkg::t_load i_load,
    input  logic          i_q_full,
    output logic          o_q_push,
    output hfu_pkg::t_cmd o_q_data
);
    import hfu_pkg::*;

    localparam int L = UNIT_LENGTH_BITS;

    logic [15:0]  r_seq, n_seq;
    logic [31:0]  r_ts, n_ts;
    logic [7:0]   r_hdr, n_hdr;
    logic [L-1:0] r_rem, n_rem;
    logic [15:0]  r_fill, n_fill;
    logic         r_frag, n_frag;
    logic         r_first, n_first;
    logic         accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic [15:0]         chunk;
        logic [L-1:0]        len;
        logic [CMP_BITS-1:0] len_c;
        logic [CMP_BITS-1:0] chunk_c;
        logic [CMP_BITS-1:0] rem_c;
        logic [7:0]          hdr;
        logic [L-1:0]        rem;
        logic [15:0]         fill;
        logic                frag;
        logic                first;
        logic                emit;
        logic [15:0]         n;
        logic [15:0]         seq;
        logic [31:0]         ts;
        logic [7:0]          fu;

        chunk = i_cfg.chunk_size;
        if (chunk == 16'd0) begin
            chunk = 16'd1;
        end else if (chunk > MAX_CHUNK) begin
            chunk = MAX_CHUNK;
        end
        len = i_in_data.unit_length;
        if (len == '0) begin
            len = L'(1);
        end
        len_c   = CMP_BITS'(len);
        chunk_c = CMP_BITS'(chunk);

        hdr   = r_hdr;
        rem   = r_rem;
        fill  = r_fill;
        frag  = r_frag;
        first = r_first;
        seq   = r_seq;
        ts    = r_ts;
        emit  = 1'b0;

        if (i_in_data.unit_start) begin
            hdr   = i_in_data.data_byte;
            first = 1'b1;
            fill  = 16'd0;
            if (len_c >= chunk_c && (len_c - CMP_BITS'(1)) > chunk_c) begin
                // header byte of a fragmented unit is swallowed
                frag = 1'b1;
                rem  = len - L'(1);
            end else begin
                frag = 1'b0;
                rem  = len;
                emit = 1'b1;
            end
        end else begin
            emit = (r_rem != '0);
        end

        rem_c = CMP_BITS'(rem);
        n     = (frag && rem_c > chunk_c) ? chunk : rem_c[15:0];
        fu    = (hdr & TYPE_MASK) | (first ? FU_START_BIT : 8'd0)
              | ((CMP_BITS'(n) == rem_c) ? FU_END_BIT : 8'd0);

        o_q_data.data_byte = i_in_data.data_byte;
        o_q_data.has_hdr   = (fill == 16'd0);
        o_q_data.has_fu    = frag;
        o_q_data.plen      = RTP_HDR_BYTES + n + (frag ? FU_HDR_BYTES : 16'd0);
        o_q_data.seq       = r_seq;
        o_q_data.ts        = r_ts;
        o_q_data.fu_ind    = (hdr & NRI_MASK) | FU_A_TYPE;
        o_q_data.fu_hdr    = fu;
        o_q_data.packet_end = 1'b0;

        if (emit) begin
            if (fill == 16'd0) begin
                // open a new packet
                seq   = r_seq + 16'd1;
                first = frag ? 1'b0 : first;
                fill  = n;
            end
            o_q_data.packet_end = (fill == 16'd1);
            fill = fill - 16'd1;
            rem  = rem - L'(1);
            if (rem == '0 && (frag || (hdr[4:0] != NAL_SPS && hdr[4:0] != NAL_PPS))) begin
                ts = r_ts + i_cfg.ts_step;
            end
        end

        o_q_push = accept && emit;

        n_hdr   = accept ? hdr   : r_hdr;
        n_rem   = accept ? rem   : r_rem;
        n_fill  = accept ? fill  : r_fill;
        n_frag  = accept ? frag  : r_frag;
        n_first = accept ? first : r_first;
        n_seq   = accept ? seq   : r_seq;
        n_ts    = accept ? ts    : r_ts;
        if (i_load.seq_load) begin
            n_seq = i_load.seq_value;
        end
        if (i_load.ts_load) begin
            n_ts = i_load.ts_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= RST_SEQ_START;
            r_ts    <= RST_TS_START;
            r_hdr   <= 8'd0;
            r_rem   <= '0;
            r_fill  <= 16'd0;
            r_frag  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_seq   <= n_seq;
            r_ts    <= n_ts;
            r_hdr   <= n_hdr;
            r_rem   <= n_rem;
            r_fill  <= n_fill;
            r_frag  <= n_frag;
            r_first <= n_first;
        end
    end

endmodule

/* hdl/hfu_queue.sv */
// ----------------------------------------------------------------------------
// hfu_queue
// small register fifo of byte commands between front and back
// ----------------------------------------------------------------------------
module hfu_queue #(
    parameter int DEPTH = hfu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hfu_pkg::t_cmd i_push_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output hfu_pkg::t_cmd o_head
);
    import hfu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign wr_en        = i_push && !o_full;
    assign rd_en        = i_pop && o_head_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        n_count = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* hdl/hfu_back.sv */
// ----------------------------------------------------------------------------
// hfu_back
// serializes queued commands into framed packet bytes with an output register
// ----------------------------------------------------------------------------
module hfu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hfu_pkg::t_cfg i_cfg,
    input  logic          i_head_valid,
    input  hfu_pkg::t_cmd i_head,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output hfu_pkg::t_out o_out_data
);
    import hfu_pkg::*;

    logic                r_mid, n_mid;
    logic [POS_BITS-1:0] r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    t_out                r_out;
    logic                load;
    logic [POS_BITS-1:0] idx;
    logic [7:0]          sel_byte;

    assign load = i_head_valid && (!r_out_valid || i_out_ready);
    assign idx  = r_mid ? r_idx : (i_head.has_hdr ? POS_MARK : POS_DATA);

    always_comb begin
        unique case (idx)
            POS_MARK:    sel_byte = INTERLEAVE_MARK;
            POS_CHANNEL: sel_byte = i_cfg.channel;
            POS_PLEN_HI: sel_byte = i_head.plen[15:8];
            POS_PLEN_LO: sel_byte = i_head.plen[7:0];
            POS_LEAD_HI: sel_byte = i_cfg.lead_word[15:8];
            POS_LEAD_LO: sel_byte = i_cfg.lead_word[7:0];
            POS_SEQ_HI:  sel_byte = i_head.seq[15:8];
            POS_SEQ_LO:  sel_byte = i_head.seq[7:0];
            POS_TS_3:    sel_byte = i_head.ts[31:24];
            POS_TS_2:    sel_byte = i_head.ts[23:16];
            POS_TS_1:    sel_byte = i_head.ts[15:8];
            POS_TS_0:    sel_byte = i_head.ts[7:0];
            POS_SSRC_3:  sel_byte = i_cfg.source_id[31:24];
            POS_SSRC_2:  sel_byte = i_cfg.source_id[23:16];
            POS_SSRC_1:  sel_byte = i_cfg.source_id[15:8];
            POS_SSRC_0:  sel_byte = i_cfg.source_id[7:0];
            POS_FU_IND:  sel_byte = i_head.fu_ind;
            POS_FU_HDR:  sel_byte = i_head.fu_hdr;
            POS_DATA:    sel_byte = i_head.data_byte;
            default:     sel_byte = 8'd0;
        endcase
    end

    always_comb begin
        o_pop       = load && (idx == POS_DATA);
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            if (idx == POS_DATA) begin
                n_mid = 1'b0;
            end else begin
                n_mid = 1'b1;
                // skip the fu bytes of a single-nal packet
                n_idx = (idx == POS_SSRC_0 && !i_head.has_fu) ? POS_DATA
                                                               : idx + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_idx       <= POS_MARK;
            r_out_valid <= 1'b0;
        end else begin
            r_mid       <= n_mid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte   <= sel_byte;
            r_out.packet_end <= (idx == POS_DATA) && i_head.packet_end;
            r_out.run_last   <= (idx == POS_DATA);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/h264_rtp_fu_a_packetizer.sv */
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// output: a word that opens a packet passes the command queue and the output
// register; its 16 or 18 header bytes come first, one per cycle while ready
// throughput: one word per cycle inside a packet while the output is ready;
// a word that opens a packet waits while the byte serializer sends its header
// reset: synchronous active low, registers to defaults, sequence and timestamp
// to their start values, queue and output emptied
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer #(
    parameter int QUEUE_DEPTH = hfu_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // nal byte input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  hfu_pkg::t_in                        i_in_data,
    // framed byte output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output hfu_pkg::t_out                       o_out_data,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [hfu_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [hfu_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import hfu_pkg::*;

    // configuration registers
    t_cfg  r_cfg;
    t_load load;

    // front to queue
    logic  q_push;
    t_cmd  q_push_data;
    logic  q_full;
    // queue to back
    logic  q_head_valid;
    t_cmd  q_head;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_word  <= RST_LEAD_WORD;
            r_cfg.source_id  <= RST_SOURCE_ID;
            r_cfg.channel    <= RST_CHANNEL;
            r_cfg.chunk_size <= RST_CHUNK_SIZE;
            r_cfg.ts_step    <= RST_TS_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEAD_WORD:  r_cfg.lead_word  <= i_cfg_data[15:0];
                CFG_SOURCE_ID:  r_cfg.source_id  <= i_cfg_data;
                CFG_CHANNEL:    r_cfg.channel    <= i_cfg_data[7:0];
                CFG_CHUNK_SIZE: r_cfg.chunk_size <= i_cfg_data[15:0];
                CFG_TS_STEP:    r_cfg.ts_step    <= i_cfg_data;
                // start values go straight into the running state
                default: ;
            endcase
        end
    end

    // start value writes reload sequence number and timestamp
    always_comb begin
        load.seq_load  = i_cfg_we && (i_cfg_index == CFG_SEQ_START);
        load.seq_value = i_cfg_data[15:0];
        load.ts_load   = i_cfg_we && (i_cfg_index == CFG_TS_START);
        load.ts_value  = i_cfg_data;
    end

    // front: unit tracking, packet decisions, sequence and timestamp
    hfu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg      (r_cfg),
        .i_load     (load),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_push_data)
    );

    // command queue lets the input run on while headers go out
    hfu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_push_data),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // back: header and data byte serializer with registered output
    hfu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule
